[rtl/core/ffpa_pkg.sv]
// ffpa_pkg: opcodes, status codes, fill characters and statistics limit of the first-fit page allocator
// no dependencies; used by first_fit_page_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_ALLOC      = 3'd1,
    OP_FREE       = 3'd2,
    OP_READ_NEXT  = 3'd3,
    OP_WRITE_NEXT = 3'd4,
    OP_READ_AT    = 3'd5,
    OP_WRITE_AT   = 3'd6,
    OP_SCRUB      = 3'd7
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_BAD_HANDLE = 3'd2,
    ST_OUT_RANGE  = 3'd3,
    ST_EXHAUSTED  = 3'd4
  } status_e;

  // fill characters
  localparam logic [7:0] FreedByte    = 8'h23;  // '#'
  localparam logic [7:0] ScrubbedByte = 8'h2E;  // '.'

  // saturation limit of the statistics fields
  localparam int unsigned StatMax = 2047;

endpackage

`default_nettype wire

[rtl/core/first_fit_page_allocator_unit.sv]
// first_fit_page_allocator_unit: paged byte store with first-fit allocation and sequencer
// depends on ffpa_pkg
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  opcode, handle, byte_count, offset, data
//  m_axis    out  m_axis_tvalid/m_axis_tready  status, handle_out, data_out, free stats
//  cfg       in   cfg_we_i                     fill_byte
//
// One transaction at a time; s_axis_tready is high only while the sequencer is idle.
// Every operation passes dispatch, then ends with a sweep over the free-page bitmap for
// the statistics, a scaling step and output.
// alloc adds a first-fit scan over up to NUM_PAGES pages and a marking of each taken page;
// free writes one byte per cycle over its pages; a byte access adds address-wrap steps,
// a store access and, for a read, a data capture; init and scrub sweep all
// NUM_PAGES*PAGE_BYTES bytes.
// After reset a clearing pass writes zero into all NUM_PAGES*PAGE_BYTES bytes before the
// first transaction is taken. A stalled result holds the block until m_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_allocator_unit #(
  parameter int unsigned NUM_PAGES   = 64,
  parameter int unsigned PAGE_BYTES  = 16,
  parameter int unsigned NUM_HANDLES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // opcode[2:0], handle[8:3], byte_count[19:9], offset[29:20], data[37:30]
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // status[2:0], handle_out[8:3], data_out[16:9], free_bytes[27:17],
  // largest_free[38:28], smallest_free[49:39]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int unsigned StoreBytes = NUM_PAGES * PAGE_BYTES;
  localparam int unsigned AW   = $clog2(StoreBytes);
  localparam int unsigned PW   = $clog2(NUM_PAGES);
  localparam int unsigned PCW  = $clog2(NUM_PAGES + 1);
  localparam int unsigned HW   = $clog2(NUM_HANDLES);
  localparam int unsigned NHW  = $clog2(NUM_HANDLES + 1);
  localparam int unsigned KW   = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int unsigned RBW  = $clog2(StoreBytes + 1);
  localparam int unsigned CMPW = (RBW > 12) ? RBW : 12;
  localparam int unsigned SW   = ((AW > 11) ? AW : 11) + 2;
  localparam int unsigned PBW  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned PRW  = (PCW + PBW > 12) ? PCW + PBW : 12;

  typedef struct packed {
    logic [PW-1:0] base;
    logic [10:0]   req;
    logic [10:0]   rptr;
    logic [10:0]   wptr;
  } hent_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_FILL, S_ASCAN, S_AMARK, S_FREE, S_SCRUB,
    S_MOD, S_ACC, S_RDAT, S_STAT, S_SCALE, S_OUT
  } state_e;

  state_e               state_q;
  logic [7:0]           fill_byte_q;
  logic [NUM_PAGES-1:0] pfree_q;
  logic [NUM_HANDLES-1:0] active_q;
  logic [NHW-1:0]       nh_q;

  ffpa_pkg::op_e        op_q;
  logic [5:0]           h_q;
  logic [10:0]          cnt_q;
  logic [9:0]           off_q;
  logic [7:0]           dat_q;

  logic [AW-1:0]        ba_q;
  logic [KW-1:0]        k_q;
  logic [PCW-1:0]       p_q;
  logic [PW-1:0]        start_q;
  logic [CMPW-1:0]      acc_q;
  logic [SW-1:0]        sum_q;

  logic [PCW-1:0]       sp_q, run_q, total_q, largest_q, smallest_q;

  ffpa_pkg::status_e    status_q;
  logic [5:0]           hout_q;
  logic [7:0]           dout_q;
  logic [10:0]          freeb_q, largb_q, smallb_q;

  // memories
  logic [7:0]           store_mem [StoreBytes];
  logic [7:0]           st_rd_q;
  hent_t                hmem [NUM_HANDLES];
  hent_t                hm_rd_q;

  logic                 st_we, st_re;
  logic [AW-1:0]        st_a;
  logic [7:0]           st_wd;
  logic                 hm_we;
  logic [HW-1:0]        hm_wa;
  hent_t                hm_wd;

  logic                 s_acc;
  logic [HW-1:0]        hidx;
  logic [HW-1:0]        in_hidx;
  logic                 hvalid;
  logic                 is_wr, is_next;
  logic [PW-1:0]        pidx;
  logic [CMPW-1:0]      acc_nx;
  logic [CMPW-1:0]      pb_c;
  logic                 stat_free;

  assign s_acc   = s_axis_tvalid & s_axis_tready;
  assign hidx    = HW'(h_q);
  assign in_hidx = HW'(s_axis_tdata[8:3]);
  assign hvalid  = (32'(h_q) < NUM_HANDLES) && active_q[hidx];
  assign is_wr   = (op_q == ffpa_pkg::OP_WRITE_NEXT) || (op_q == ffpa_pkg::OP_WRITE_AT);
  assign is_next = (op_q == ffpa_pkg::OP_READ_NEXT) || (op_q == ffpa_pkg::OP_WRITE_NEXT);
  assign pidx    = p_q[PW-1:0];
  assign pb_c    = CMPW'(PAGE_BYTES);
  assign acc_nx  = acc_q + pb_c;
  assign stat_free = (sp_q < PCW'(NUM_PAGES)) && pfree_q[sp_q[PW-1:0]];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, smallb_q, largb_q, freeb_q, dout_q, hout_q, status_q};

  // saturate a scaled statistic to the field width
  function automatic logic [10:0] sat11(input logic [PRW-1:0] v);
    logic [10:0] r;
    if (v > PRW'(ffpa_pkg::StatMax)) r = 11'(ffpa_pkg::StatMax);
    else r = v[10:0];
    return r;
  endfunction

  // store port and handle table write control
  always_comb begin
    st_we = 1'b0;
    st_re = 1'b0;
    st_a  = ba_q;
    st_wd = 8'd0;
    hm_we = 1'b0;
    hm_wa = hidx;
    hm_wd = hm_rd_q;
    case (state_q)
      S_CLR: begin
        st_we = 1'b1;
      end
      S_FILL: begin
        st_we = 1'b1;
        st_wd = fill_byte_q;
      end
      S_FREE: begin
        st_we = 1'b1;
        st_wd = ffpa_pkg::FreedByte;
      end
      S_SCRUB: begin
        st_we = pfree_q[pidx];
        st_wd = ffpa_pkg::ScrubbedByte;
      end
      S_ACC: begin
        st_a  = sum_q[AW-1:0];
        st_we = is_wr;
        st_re = !is_wr;
        st_wd = dat_q;
        if (op_q == ffpa_pkg::OP_READ_NEXT) begin
          hm_we = 1'b1;
          hm_wd.rptr = hm_rd_q.rptr + 11'd1;
        end else if (op_q == ffpa_pkg::OP_WRITE_NEXT) begin
          hm_we = 1'b1;
          hm_wd.wptr = hm_rd_q.wptr + 11'd1;
        end
      end
      S_ASCAN: begin
        // handle entry is written when the fit is found and a handle is left
        hm_wa = HW'(nh_q);
        hm_wd = '{base: start_q, req: cnt_q, rptr: 11'd0, wptr: 11'd0};
        if (pfree_q[pidx] && ((acc_q == '0) ? (pb_c >= CMPW'(cnt_q))
                                             : (acc_nx >= CMPW'(cnt_q)))
            && (32'(nh_q) < NUM_HANDLES)) begin
          hm_we = 1'b1;
          if (acc_q == '0) hm_wd.base = pidx;
        end
      end
      default: begin
      end
    endcase
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_a] <= st_wd;
    if (st_re) st_rd_q <= store_mem[st_a];
  end

  // handle table
  always_ff @(posedge clk_i) begin
    if (hm_we) hmem[hm_wa] <= hm_wd;
    if (s_acc) hm_rd_q <= hmem[in_hidx];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      fill_byte_q <= 8'd0;
      pfree_q     <= '1;
      active_q    <= '0;
      nh_q        <= '0;
      ba_q        <= '0;
    end else begin
      if (cfg_we_i) fill_byte_q <= cfg_wdata_i;
      case (state_q)
        S_CLR: begin
          ba_q <= ba_q + AW'(1);
          if (ba_q == AW'(StoreBytes - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_acc) begin
            op_q     <= ffpa_pkg::op_e'(s_axis_tdata[2:0]);
            h_q      <= s_axis_tdata[8:3];
            cnt_q    <= s_axis_tdata[19:9];
            off_q    <= s_axis_tdata[29:20];
            dat_q    <= s_axis_tdata[37:30];
            status_q <= ffpa_pkg::ST_OK;
            hout_q   <= 6'd0;
            dout_q   <= 8'd0;
            state_q  <= S_DISP;
          end
        end
        S_DISP: begin
          sp_q       <= '0;
          run_q      <= '0;
          total_q    <= '0;
          largest_q  <= '0;
          smallest_q <= '0;
          ba_q       <= '0;
          k_q        <= '0;
          p_q        <= '0;
          acc_q      <= '0;
          state_q    <= S_STAT;
          case (op_q)
            ffpa_pkg::OP_INIT: begin
              active_q <= '0;
              pfree_q  <= '1;
              nh_q     <= '0;
              state_q  <= S_FILL;
            end
            ffpa_pkg::OP_ALLOC: begin
              if (cnt_q == 11'd0) status_q <= ffpa_pkg::ST_OUT_RANGE;
              else state_q <= S_ASCAN;
            end
            ffpa_pkg::OP_FREE: begin
              if (!hvalid) begin
                status_q <= ffpa_pkg::ST_BAD_HANDLE;
              end else begin
                active_q[hidx] <= 1'b0;
                p_q     <= PCW'(hm_rd_q.base);
                ba_q    <= AW'(AW'(hm_rd_q.base) * AW'(PAGE_BYTES));
                state_q <= S_FREE;
              end
            end
            ffpa_pkg::OP_READ_NEXT, ffpa_pkg::OP_WRITE_NEXT: begin
              if (!hvalid) begin
                status_q <= ffpa_pkg::ST_BAD_HANDLE;
              end else if ((is_wr ? hm_rd_q.wptr : hm_rd_q.rptr) >= hm_rd_q.req) begin
                status_q <= ffpa_pkg::ST_OUT_RANGE;
              end else begin
                sum_q   <= SW'(hm_rd_q.base) * SW'(PAGE_BYTES)
                         + SW'(is_wr ? hm_rd_q.wptr : hm_rd_q.rptr);
                state_q <= S_MOD;
              end
            end
            ffpa_pkg::OP_READ_AT, ffpa_pkg::OP_WRITE_AT: begin
              if (!hvalid) begin
                status_q <= ffpa_pkg::ST_BAD_HANDLE;
              end else if (12'(off_q) + 12'(cnt_q) > 12'(hm_rd_q.req)) begin
                status_q <= ffpa_pkg::ST_OUT_RANGE;
              end else if (cnt_q != 11'd0) begin
                sum_q   <= SW'(hm_rd_q.base) * SW'(PAGE_BYTES) + SW'(off_q);
                state_q <= S_MOD;
              end
            end
            default: begin
              state_q <= S_SCRUB;
            end
          endcase
        end
        S_FILL: begin
          ba_q <= ba_q + AW'(1);
          if (ba_q == AW'(StoreBytes - 1)) state_q <= S_STAT;
        end
        // first-fit scan, one page per cycle
        S_ASCAN: begin
          if (pfree_q[pidx]) begin
            if (acc_q == '0) start_q <= pidx;
            if (((acc_q == '0) ? pb_c : acc_nx) >= CMPW'(cnt_q)) begin
              if (32'(nh_q) >= NUM_HANDLES) begin
                status_q <= ffpa_pkg::ST_EXHAUSTED;
                state_q  <= S_STAT;
              end else begin
                active_q[HW'(nh_q)] <= 1'b1;
                hout_q  <= 6'(nh_q);
                nh_q    <= nh_q + NHW'(1);
                p_q     <= (acc_q == '0) ? p_q : PCW'(start_q);
                acc_q   <= '0;
                state_q <= S_AMARK;
              end
            end else begin
              acc_q <= (acc_q == '0) ? pb_c : acc_nx;
              p_q   <= p_q + PCW'(1);
              if (p_q == PCW'(NUM_PAGES - 1)) begin
                status_q <= ffpa_pkg::ST_NO_SPACE;
                state_q  <= S_STAT;
              end
            end
          end else begin
            acc_q <= '0;
            p_q   <= p_q + PCW'(1);
            if (p_q == PCW'(NUM_PAGES - 1)) begin
              status_q <= ffpa_pkg::ST_NO_SPACE;
              state_q  <= S_STAT;
            end
          end
        end
        // take the pages of the new area
        S_AMARK: begin
          pfree_q[pidx] <= 1'b0;
          p_q   <= p_q + PCW'(1);
          acc_q <= acc_nx;
          if (acc_nx >= CMPW'(cnt_q)) state_q <= S_STAT;
        end
        // release the area page by page, one byte per cycle
        S_FREE: begin
          ba_q <= ba_q + AW'(1);
          k_q  <= k_q + KW'(1);
          if (k_q == KW'(PAGE_BYTES - 1)) begin
            pfree_q[pidx] <= 1'b1;
            k_q   <= '0;
            p_q   <= p_q + PCW'(1);
            acc_q <= acc_nx;
            if (acc_nx >= CMPW'(hm_rd_q.req)) state_q <= S_STAT;
          end
        end
        S_SCRUB: begin
          ba_q <= ba_q + AW'(1);
          k_q  <= k_q + KW'(1);
          if (k_q == KW'(PAGE_BYTES - 1)) begin
            k_q <= '0;
            p_q <= p_q + PCW'(1);
          end
          if (ba_q == AW'(StoreBytes - 1)) state_q <= S_STAT;
        end
        // wrap the byte address into the store
        S_MOD: begin
          if (sum_q >= SW'(StoreBytes)) sum_q <= sum_q - SW'(StoreBytes);
          else state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= is_wr ? S_STAT : S_RDAT;
        end
        S_RDAT: begin
          dout_q  <= st_rd_q;
          state_q <= S_STAT;
        end
        // free-run statistics over the bitmap
        S_STAT: begin
          sp_q <= sp_q + PCW'(1);
          if (stat_free) begin
            run_q   <= run_q + PCW'(1);
            total_q <= total_q + PCW'(1);
          end else if (run_q != '0) begin
            if (run_q > largest_q) largest_q <= run_q;
            if (smallest_q == '0 || run_q < smallest_q) smallest_q <= run_q;
            run_q <= '0;
          end
          if (sp_q == PCW'(NUM_PAGES)) state_q <= S_SCALE;
        end
        S_SCALE: begin
          freeb_q  <= sat11(PRW'(total_q) * PRW'(PAGE_BYTES));
          largb_q  <= sat11(PRW'(largest_q) * PRW'(PAGE_BYTES));
          smallb_q <= sat11(PRW'(smallest_q) * PRW'(PAGE_BYTES));
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("input taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready) else $error("ready right after a transaction");

  a_handle_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nh_q) <= NUM_HANDLES) else $error("handle counter beyond limit");

  a_stats_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (largb_q <= freeb_q) && (smallb_q <= largb_q))
    else $error("free statistics out of order");

  a_alloc_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q != ffpa_pkg::ST_OK) |-> (hout_q == 6'd0 && dout_q == 8'd0))
    else $error("payload on a failed transaction");

endmodule

`default_nettype wire
